// ===== rtl/core/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, opcodes and control/status bundles of the coalescent
// topology sampler.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_LEAVES = 64;
  localparam int DRAW_BITS  = 16;
  localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
  localparam int IDX_W      = $clog2(NODE_DEPTH);
  localparam int TGT_W      = DRAW_BITS + IDX_W;

  // fixed field widths
  localparam int LT_W   = 7;
  localparam int CMD_W  = 2;
  localparam int TIME_W = 32;
  localparam int FLD_W  = 7;
  localparam int LEN_W  = 33;

  typedef enum logic [CMD_W-1:0] {
    OP_START = 2'd0,
    OP_LEAF  = 2'd1,
    OP_MERGE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic load;       // capture input word
    logic start;      // reload counters, clear flags
    logic leaf_step;  // activate one leaf
    logic pick_init;  // set up a cumulative pick
    logic second;     // second child of the merge
    logic scan_step;  // examine one node flag
    logic emit;       // load edge word into the output register
    logic emit_err;   // load error word into the output register
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic leaf_done;
    logic too_few;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/coalescent_topology_sampler.sv =====
// ----------------------------------------------------------------------------
// coalescent_topology_sampler
// Builds a random coalescent genealogy one event word at a time.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write leaf_total (always ready); write only while the block is idle.
//   in_*   : one command word per valid/ready handshake. in_ready is high only
//            while no word is in progress.
//   out_*  : result words, registered; a coalesce gives an edge word per child (the
//            second with out_last_of_run) or one error word. Start, add-leaves
//            and unused commands give no word.
// The pick scan of a coalesce examines one of the 127 node flags per cycle
//   and runs twice per merge (it stops at the hit).
// Reset clears node flags and counts at once (no clearing pass), sets node
//   indices for two leaves, loads leaf_total = 2; the time memory is not cleared.
// A stalled receiver holds the output word; the sequencer then waits before
//   loading the next word, and no further input is taken until the coalesce
//   word sequence is loaded.
// ----------------------------------------------------------------------------
module coalescent_topology_sampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cts_pkg::LT_W-1:0]          cfg_leaf_total,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cts_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [cts_pkg::TIME_W-1:0] in_event_time,
  input  logic [cts_pkg::LT_W-1:0]          in_leaf_count,
  input  logic [cts_pkg::DRAW_BITS-1:0]     in_draw_first,
  input  logic [cts_pkg::DRAW_BITS-1:0]     in_draw_second,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cts_pkg::FLD_W-1:0]         out_edge_slot,
  output logic [cts_pkg::FLD_W-1:0]         out_parent_node,
  output logic [cts_pkg::FLD_W-1:0]         out_child_node,
  output logic signed [cts_pkg::LEN_W-1:0]  out_branch_length,
  output logic [cts_pkg::FLD_W-1:0]         out_lineages_before,
  output logic                              out_status,
  output logic                              out_last_of_run
);
  import cts_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_ready = 1'b1;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (dp_cmd)
  );

  cts_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_leaf_total      (cfg_leaf_total),
    .in_cmd              (in_cmd),
    .in_event_time       (in_event_time),
    .in_leaf_count       (in_leaf_count),
    .in_draw_first       (in_draw_first),
    .in_draw_second      (in_draw_second),
    .cmd_i               (dp_cmd),
    .stat_o              (dp_stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_edge_slot       (out_edge_slot),
    .out_parent_node     (out_parent_node),
    .out_child_node      (out_child_node),
    .out_branch_length   (out_branch_length),
    .out_lineages_before (out_lineages_before),
    .out_status          (out_status),
    .out_last_of_run     (out_last_of_run)
  );

  // a word is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.emit || dp_cmd.emit_err) |-> dp_stat.out_free)
    else $error("output word overwritten");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_last_of_run && out_child_node == '0))
    else $error("malformed error word");

  a_edge_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_child_node != out_parent_node))
    else $error("edge joins a node to itself");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.scan_step || dp_cmd.leaf_step) |-> !in_ready)
    else $error("input taken while a word is in progress");

endmodule

// ===== rtl/core/cts_ctrl.sv =====
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer: decodes each input word and steps the datapath through leaf
// insertion, the two cumulative picks and the result words.
// ----------------------------------------------------------------------------
module cts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cts_pkg::dp_stat_t stat_i,
  output cts_pkg::dp_cmd_t  cmd_o
);
  import cts_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_LEAF     = 10'b00_0000_0100,
    S_INIT1    = 10'b00_0000_1000,
    S_SCAN1    = 10'b00_0001_0000,
    S_EMIT1    = 10'b00_0010_0000,
    S_INIT2    = 10'b00_0100_0000,
    S_SCAN2    = 10'b00_1000_0000,
    S_EMIT2    = 10'b01_0000_0000,
    S_ERR      = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_START: begin
            cmd_o.start = 1'b1;
            state_nxt   = S_IDLE;
          end
          OP_LEAF:  state_nxt = S_LEAF;
          OP_MERGE: state_nxt = stat_i.too_few ? S_ERR : S_INIT1;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_LEAF: begin
        if (stat_i.leaf_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd_o.leaf_step = 1'b1;
        end
      end
      S_INIT1: begin
        cmd_o.pick_init = 1'b1;
        state_nxt       = S_SCAN1;
      end
      S_SCAN1: begin
        if (stat_i.scan_done) begin
          state_nxt = S_EMIT1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT1: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_INIT2;
        end
      end
      S_INIT2: begin
        cmd_o.second    = 1'b1;
        cmd_o.pick_init = 1'b1;
        state_nxt       = S_SCAN2;
      end
      S_SCAN2: begin
        cmd_o.second = 1'b1;
        if (stat_i.scan_done) begin
          state_nxt = S_EMIT2;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_EMIT2: begin
        cmd_o.second = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/cts_dpath.sv =====
// ----------------------------------------------------------------------------
// cts_dpath
// Datapath: node flags, node time memory, tree counters, the one-flag-a-cycle
// cumulative pick and the output word register.
// ----------------------------------------------------------------------------
module cts_dpath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic [cts_pkg::LT_W-1:0]               cfg_leaf_total,
  input  logic [cts_pkg::CMD_W-1:0]              in_cmd,
  input  logic signed [cts_pkg::TIME_W-1:0]      in_event_time,
  input  logic [cts_pkg::LT_W-1:0]               in_leaf_count,
  input  logic [cts_pkg::DRAW_BITS-1:0]          in_draw_first,
  input  logic [cts_pkg::DRAW_BITS-1:0]          in_draw_second,
  input  cts_pkg::dp_cmd_t                       cmd_i,
  output cts_pkg::dp_stat_t                      stat_o,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [cts_pkg::FLD_W-1:0]              out_edge_slot,
  output logic [cts_pkg::FLD_W-1:0]              out_parent_node,
  output logic [cts_pkg::FLD_W-1:0]              out_child_node,
  output logic signed [cts_pkg::LEN_W-1:0]       out_branch_length,
  output logic [cts_pkg::FLD_W-1:0]              out_lineages_before,
  output logic                                   out_status,
  output logic                                   out_last_of_run
);
  import cts_pkg::*;

  // configuration
  logic [LT_W-1:0]      leaf_total_r;
  logic [IDX_W-1:0]     lt_sat;

  // captured word
  logic [CMD_W-1:0]     cmd_r;
  logic [TIME_W-1:0]    et_r;
  logic [LT_W-1:0]      lc_r, lc_nxt;
  logic [DRAW_BITS-1:0] d1_r, d2_r;

  // tree state; nl_r and mc_r go to minus one, the top bit flags that
  logic [NODE_DEPTH-1:0] flags_r, flags_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      nl_r, nl_nxt;
  logic [IDX_W-1:0]      ni_r, ni_nxt;
  logic [IDX_W-1:0]      mc_r, mc_nxt;
  logic                  nl_neg, mc_neg;

  // pick
  logic [TGT_W-1:0]     target_r, target_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt, k_inc;
  logic [IDX_W-1:0]     last_r, last_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic                 done_r, done_nxt;
  logic                 flag_cur, hit;
  logic [DRAW_BITS-1:0] draw_sel;
  logic [IDX_W-1:0]     n_sel;

  // time memory
  logic [TIME_W-1:0]    time_mem [NODE_DEPTH];
  logic [TIME_W-1:0]    rdata_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;

  // output register
  logic                    out_valid_r, out_free;
  logic [FLD_W-1:0]        slot_r, parent_r, child_r, lin_r;
  logic signed [LEN_W-1:0] len_r, len_w;
  logic                    status_r, last_run_r;

  assign nl_neg = nl_r[IDX_W-1];
  assign mc_neg = mc_r[IDX_W-1];

  always_comb begin
    if (int'(leaf_total_r) < 2) begin
      lt_sat = IDX_W'(2);
    end else if (int'(leaf_total_r) > MAX_LEAVES) begin
      lt_sat = IDX_W'(MAX_LEAVES);
    end else begin
      lt_sat = IDX_W'(leaf_total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_total_r <= LT_W'(2);
    end else if (cfg_valid) begin
      leaf_total_r <= cfg_leaf_total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r <= in_cmd;
      et_r  <= in_event_time;
      d1_r  <= in_draw_first;
      d2_r  <= in_draw_second;
    end
  end

  // ---- tree counters and flags ----
  always_comb begin
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    nl_nxt    = nl_r;
    ni_nxt    = ni_r;
    mc_nxt    = mc_r;
    lc_nxt    = lc_r;
    mem_we    = 1'b0;
    mem_waddr = nl_r;
    if (cmd_i.load) begin
      lc_nxt = in_leaf_count;
    end
    if (cmd_i.start) begin
      flags_nxt = '0;
      cnt_nxt   = '0;
      nl_nxt    = lt_sat - IDX_W'(1);
      ni_nxt    = IDX_W'({1'b0, lt_sat, 1'b0} - (IDX_W + 1)'(2));
      mc_nxt    = lt_sat - IDX_W'(2);
    end
    if (cmd_i.leaf_step) begin
      if (!flags_r[nl_r]) begin
        cnt_nxt = cnt_r + IDX_W'(1);
      end
      flags_nxt[nl_r] = 1'b1;
      mem_we          = 1'b1;
      nl_nxt          = nl_r - IDX_W'(1);
      lc_nxt          = lc_r - LT_W'(1);
    end
    if (cmd_i.emit) begin
      flags_nxt[pick_r] = 1'b0;
      if (cmd_i.second) begin
        // commit the merge: new internal node becomes a lineage
        flags_nxt[ni_r] = 1'b1;
        mem_we          = 1'b1;
        mem_waddr       = ni_r;
        cnt_nxt         = cnt_r - IDX_W'(1);
        mc_nxt          = mc_r - IDX_W'(1);
        ni_nxt          = ni_r - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      cnt_r   <= '0;
      nl_r    <= IDX_W'(1);
      ni_r    <= IDX_W'(2);
      mc_r    <= '0;
      lc_r    <= '0;
    end else begin
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
      nl_r    <= nl_nxt;
      ni_r    <= ni_nxt;
      mc_r    <= mc_nxt;
      lc_r    <= lc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[mem_waddr] <= et_r;
    end
    rdata_r <= time_mem[pick_r];
  end

  // ---- cumulative pick: first active node with k * 2^DRAW_BITS >= d * n ----
  assign draw_sel = cmd_i.second ? d2_r : d1_r;
  assign n_sel    = cmd_i.second ? (cnt_r - IDX_W'(1)) : cnt_r;
  assign flag_cur = flags_r[idx_r];
  assign k_inc    = k_r + IDX_W'(1);
  assign hit      = flag_cur && ({k_inc, {DRAW_BITS{1'b0}}} >= target_r);

  always_comb begin
    target_nxt = target_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    last_nxt   = last_r;
    pick_nxt   = pick_r;
    done_nxt   = done_r;
    if (cmd_i.pick_init) begin
      target_nxt = TGT_W'(draw_sel) * TGT_W'(n_sel);
      idx_nxt    = '0;
      k_nxt      = '0;
      last_nxt   = '0;
      done_nxt   = 1'b0;
    end else if (cmd_i.scan_step) begin
      if (flag_cur) begin
        k_nxt    = k_inc;
        last_nxt = idx_r;
      end
      if (hit) begin
        pick_nxt = idx_r;
        done_nxt = 1'b1;
      end else if (idx_r == IDX_W'(NODE_DEPTH - 1)) begin
        // ran off the end: clamp to the last active node
        pick_nxt = flag_cur ? idx_r : last_r;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    last_r   <= last_nxt;
    pick_r   <= pick_nxt;
  end

  // ---- output word register ----
  assign out_free = !out_valid_r || out_ready;
  assign len_w    = $signed({rdata_r[TIME_W-1], rdata_r}) - $signed({et_r[TIME_W-1], et_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      slot_r     <= FLD_W'({mc_r, !cmd_i.second});
      parent_r   <= FLD_W'({1'b0, ni_r} + (IDX_W + 1)'(1));
      child_r    <= FLD_W'({1'b0, pick_r} + (IDX_W + 1)'(1));
      len_r      <= len_w;
      lin_r      <= FLD_W'(cnt_r);
      status_r   <= 1'b0;
      last_run_r <= cmd_i.second;
    end else if (cmd_i.emit_err) begin
      slot_r     <= '0;
      parent_r   <= '0;
      child_r    <= '0;
      len_r      <= '0;
      lin_r      <= FLD_W'(cnt_r);
      status_r   <= 1'b1;
      last_run_r <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_edge_slot       = slot_r;
  assign out_parent_node     = parent_r;
  assign out_child_node      = child_r;
  assign out_branch_length   = len_r;
  assign out_lineages_before = lin_r;
  assign out_status          = status_r;
  assign out_last_of_run     = last_run_r;

  always_comb begin
    stat_o.op        = op_t'(cmd_r);
    stat_o.leaf_done = (lc_r == '0) || nl_neg;
    stat_o.too_few   = (cnt_r < IDX_W'(2)) || mc_neg;
    stat_o.scan_done = done_r;
    stat_o.out_free  = out_free;
  end

endmodule
